### src/msort_pkg.sv
// ----------------------------------------------------------------------------
// msort_pkg
// shared sizes, types and element conversions for the merge sorter
// ----------------------------------------------------------------------------
package msort_pkg;

   // store capacity and stored element width
   localparam int MAX_ELEMENTS  = 1024;
   localparam int ELEMENT_WIDTH = 32;

   // fixed port widths
   localparam int VALUE_W = 32;
   localparam int WIDE_W  = 64;

   // derived sizes
   localparam int ADDR_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int EXT_W  = CNT_W + 1;
   localparam int SUM_W  = CNT_W + 2;

   // request action codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef logic [ELEMENT_WIDTH-1:0] elem_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_PASS,
      ST_MERGE,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_en;
      logic rd_capture;
      logic sort_init;
      logic pass_init;
      logic merge_en;
      logic mark_sorted;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic few;
      logic pass_end;
      logic last_pass;
   } stat_type;

   // sign-extend a request value into a stored element
   function automatic elem_type to_elem(input logic signed [VALUE_W-1:0] v);
      logic signed [WIDE_W-1:0] wide;
      wide = WIDE_W'(v);
      return ELEMENT_WIDTH'(wide);
   endfunction

   // low bits of a stored element
   function automatic logic signed [VALUE_W-1:0] from_elem(input elem_type e);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(e);
      return VALUE_W'(wide);
   endfunction

endpackage

### src/msort_ram.sv
// ----------------------------------------------------------------------------
// msort_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module msort_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### src/msort_ctrl.sv
// ----------------------------------------------------------------------------
// msort_ctrl
// sequencer for load, sort passes and read responses
// ----------------------------------------------------------------------------
module msort_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_action,
   input  logic               req_last_load,
   input  msort_pkg::stat_type stat,
   output msort_pkg::cmd_type  cmd,
   output logic               busy,
   output logic               rsp_valid
);
   import msort_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_action == ACT_READ) begin
                  cmd.rd_capture = 1'b1;
                  state_in       = ST_RESP;
               end else begin
                  cmd.load_en = 1'b1;
                  if (req_last_load) begin
                     state_in = ST_SETUP;
                  end
               end
            end
         end
         ST_SETUP: begin
            cmd.sort_init = 1'b1;
            if (stat.few) begin
               cmd.mark_sorted = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               state_in = ST_PASS;
            end
         end
         ST_PASS: begin
            cmd.pass_init = 1'b1;
            state_in      = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge_en = 1'b1;
            if (stat.pass_end) begin
               if (stat.last_pass) begin
                  cmd.mark_sorted = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  state_in = ST_PASS;
               end
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### src/msort_dp.sv
// ----------------------------------------------------------------------------
// msort_dp
// element stores, merge pointers and read response registers
// ----------------------------------------------------------------------------
module msort_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  msort_pkg::cmd_type                    cmd,
   input  logic signed [msort_pkg::VALUE_W-1:0]  req_value,
   output msort_pkg::stat_type                   stat,
   output logic signed [msort_pkg::VALUE_W-1:0]  rsp_sorted_value,
   output logic                                  rsp_is_last,
   output logic                                  rsp_none_left
);
   import msort_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rp_ff, rp_in;
   logic             sorted_ff, sorted_in;
   logic             sel_ff, sel_in;     // 1: sorted data lives in store b
   logic [EXT_W-1:0] w_ff, w_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic             last_ff, last_in;
   logic             none_ff, none_in;

   elem_type         a_rd0, a_rd1, b_rd0, b_rd1;
   elem_type         src_l, src_r, merge_data;
   logic             take_left, group_end, pass_end, last_pass;
   logic [CNT_W-1:0] eff_count, gbase, gmid, ghi;
   logic [SUM_W-1:0] s1, s2, nn;
   logic             room, rd_avail;
   logic             a_we, b_we;
   logic [ADDR_W-1:0] a_waddr, b_waddr, rd_addr0, rd_addr1;
   elem_type         a_wdata;

   always_comb begin
      src_l      = sel_ff ? b_rd0 : a_rd0;
      src_r      = sel_ff ? b_rd1 : a_rd1;
      take_left  = (i_ff < mid_ff) &&
                   ((j_ff >= hi_ff) || ($signed(src_l) < $signed(src_r)));
      merge_data = take_left ? src_l : src_r;
      group_end  = (k_ff + CNT_W'(1)) == hi_ff;
      pass_end   = (k_ff + CNT_W'(1)) == count_ff;
      nn         = SUM_W'(count_ff);
      last_pass  = (SUM_W'(w_ff) + SUM_W'(w_ff)) >= nn;

      // bounds of the next run pair
      gbase = cmd.pass_init ? '0 : hi_ff;
      s1    = SUM_W'(gbase) + SUM_W'(w_ff);
      s2    = s1 + SUM_W'(w_ff);
      gmid  = (s1 < nn) ? CNT_W'(s1) : count_ff;
      ghi   = (s2 < nn) ? CNT_W'(s2) : count_ff;

      eff_count = sorted_ff ? '0 : count_ff;
      room      = eff_count < CNT_W'(MAX_ELEMENTS);
      rd_avail  = sorted_ff && (rp_ff < count_ff);

      count_in  = count_ff;
      rp_in     = rp_ff;
      sorted_in = sorted_ff;
      sel_in    = sel_ff;
      w_in      = w_ff;
      k_in      = k_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      mid_in    = mid_ff;
      hi_in     = hi_ff;
      last_in   = last_ff;
      none_in   = none_ff;

      if (cmd.load_en) begin
         sorted_in = 1'b0;
         if (sorted_ff) begin
            rp_in = '0;
         end
         count_in = eff_count + CNT_W'(room);
      end
      if (cmd.rd_capture) begin
         none_in = !rd_avail;
         last_in = rd_avail && ((rp_ff + CNT_W'(1)) == count_ff);
         if (rd_avail) begin
            rp_in = rp_ff + CNT_W'(1);
         end
      end
      if (cmd.sort_init) begin
         w_in   = EXT_W'(1);
         sel_in = 1'b0;
         k_in   = '0;
      end
      if (cmd.pass_init) begin
         i_in   = '0;
         j_in   = gmid;
         mid_in = gmid;
         hi_in  = ghi;
         k_in   = '0;
      end
      if (cmd.merge_en) begin
         if (pass_end) begin
            w_in   = w_ff << 1;
            sel_in = !sel_ff;
            k_in   = '0;
         end else if (group_end) begin
            i_in   = hi_ff;
            j_in   = gmid;
            mid_in = gmid;
            hi_in  = ghi;
            k_in   = k_ff + CNT_W'(1);
         end else begin
            if (take_left) begin
               i_in = i_ff + CNT_W'(1);
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
            k_in = k_ff + CNT_W'(1);
         end
      end
      if (cmd.mark_sorted) begin
         sorted_in = 1'b1;
         rp_in     = '0;
      end

      // reads are issued from next pointers so data lines up with the pointers
      rd_addr0 = (cmd.pass_init || cmd.merge_en) ? i_in[ADDR_W-1:0] : rp_ff[ADDR_W-1:0];
      rd_addr1 = j_in[ADDR_W-1:0];

      a_we    = (cmd.load_en && room) || (cmd.merge_en && sel_ff);
      a_waddr = cmd.load_en ? eff_count[ADDR_W-1:0] : k_ff[ADDR_W-1:0];
      a_wdata = cmd.load_en ? to_elem(req_value) : merge_data;
      b_we    = cmd.merge_en && !sel_ff;
      b_waddr = k_ff[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rp_ff     <= '0;
         sorted_ff <= 1'b0;
         sel_ff    <= 1'b0;
         w_ff      <= '0;
         k_ff      <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         mid_ff    <= '0;
         hi_ff     <= '0;
         last_ff   <= 1'b0;
         none_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rp_ff     <= rp_in;
         sorted_ff <= sorted_in;
         sel_ff    <= sel_in;
         w_ff      <= w_in;
         k_ff      <= k_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         mid_ff    <= mid_in;
         hi_ff     <= hi_in;
         last_ff   <= last_in;
         none_ff   <= none_in;
      end
   end

   msort_ram #(
      .WIDTH (ELEMENT_WIDTH),
      .DEPTH (MAX_ELEMENTS)
   ) u_store_a (
      .clock     (clock),
      .wr_en     (a_we),
      .wr_addr   (a_waddr),
      .wr_data   (a_wdata),
      .rd_addr_a (rd_addr0),
      .rd_addr_b (rd_addr1),
      .rd_data_a (a_rd0),
      .rd_data_b (a_rd1)
   );

   msort_ram #(
      .WIDTH (ELEMENT_WIDTH),
      .DEPTH (MAX_ELEMENTS)
   ) u_store_b (
      .clock     (clock),
      .wr_en     (b_we),
      .wr_addr   (b_waddr),
      .wr_data   (merge_data),
      .rd_addr_a (rd_addr0),
      .rd_addr_b (rd_addr1),
      .rd_data_a (b_rd0),
      .rd_data_b (b_rd1)
   );

   assign stat.few         = count_ff <= CNT_W'(1);
   assign stat.pass_end    = pass_end;
   assign stat.last_pass   = last_pass;

   assign rsp_sorted_value = none_ff ? '0 : from_elem(src_l);
   assign rsp_is_last      = last_ff;
   assign rsp_none_left    = none_ff;

endmodule

### src/merge_sorter_top.sv
// ----------------------------------------------------------------------------
// merge_sorter_top
// loads a set of signed elements, merge sorts them, returns them in order
// ----------------------------------------------------------------------------
// usage
//   a request beat is taken at a clock edge with start high and busy low.
//   req_action selects load (element in req_value) or read of the next
//   sorted element. a load with req_last_load closes the set and sorts it.
//   loads past the store capacity are dropped; a load after a sorted set
//   begins a new set.
// sequencing
//   loads are taken one per cycle, back to back, until the closing load.
//   sorting n elements keeps busy high through a setup state, then
//   ceil(log2 n) merge passes of a pointer setup state plus a merge state
//   moving one element per cycle through the dual-read store; n <= 1 ends
//   at setup. a read's result beat comes in the cycle after it is taken,
//   with busy high in that cycle, so no new read is taken before that beat.
// reset
//   synchronous, active high: the set is empty and nothing is sorted.
//   the element stores need no clearing.
// results
//   each result beat sits on the rsp_ ports for exactly one cycle with
//   rsp_valid high; the receiver cannot stall. reads before the set is
//   sorted or past its end return rsp_none_left with a zero value.
// ----------------------------------------------------------------------------
module merge_sorter_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_action,
   input  logic signed [msort_pkg::VALUE_W-1:0] req_value,
   input  logic                                 req_last_load,
   output logic                                 rsp_valid,
   output logic signed [msort_pkg::VALUE_W-1:0] rsp_sorted_value,
   output logic                                 rsp_is_last,
   output logic                                 rsp_none_left
);
   import msort_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: idle, sort setup, pass setup, merge, response
   msort_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_action    (req_action),
      .req_last_load (req_last_load),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_valid     (rsp_valid)
   );

   // ping-pong stores, merge pointers and response flags
   msort_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_value        (req_value),
      .stat             (stat),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_is_last      (rsp_is_last),
      .rsp_none_left    (rsp_none_left)
   );

   // every taken read gets its result beat in the next cycle
   a_read_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_READ)) |=> rsp_valid)
      else $error("read beat without result");

   // loads never produce a result
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_LOAD)) |=> !rsp_valid)
      else $error("result after load beat");

   // result beats are single cycle strobes
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held");

   // an empty read carries neither last mark nor data
   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_none_left) |-> (!rsp_is_last && (rsp_sorted_value == '0)))
      else $error("empty read carries data");

endmodule
